FILE: rtl/hpd_pkg.sv
// shared constants and types for the heading pd differential thrust block
`default_nettype none

package hpd_pkg;

    // field widths
    localparam int HEADING_W = 12;
    localparam int RANGE_W   = 16;
    localparam int ERROR_W   = 12;
    localparam int DRIVE_W   = 11;
    localparam int WIDTH_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // controller constants
    localparam int RANGE_SAT   = 120;
    localparam int HALF_TURN   = 1800;
    localparam int FULL_TURN   = 3600;
    localparam int DRIVE_LIMIT = 1000;

    // divide by ten: floor(n * 838861 / 2^23) is exact for n below 2^22
    localparam int DIV10_MUL   = 838861;
    localparam int DIV10_SHIFT = 23;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_HEADING = 3'd0,
        CFG_KP_TENTHS      = 3'd1,
        CFG_KD_GAIN        = 3'd2,
        CFG_PW_NEUTRAL     = 3'd3,
        CFG_PW_MIN         = 3'd4,
        CFG_PW_MAX         = 3'd5
    } cfg_index_t;

endpackage

`default_nettype wire

FILE: rtl/heading_pd_differential_thrust.sv
// Heading PD controller with angle wrap and differential thrust outputs.
// Five register stages lie between input accept and result valid
// (input, error, products, divide-by-ten multiply, clamp/output).
// Throughput: one item per cycle; each stage moves when its successor frees up.
// Reset (aresetn low, synchronous): pipeline emptied, last error cleared,
// registers back to target 0, kp 10, kd 0, neutral 2765, min 2028, max 3502.
`default_nettype none

module heading_pd_differential_thrust (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input items
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [hpd_pkg::HEADING_W-1:0]        s_heading_now,
    input  wire logic [hpd_pkg::RANGE_W-1:0]          s_range_cm,
    input  wire logic                                 s_adjust_enable,
    // result items
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [hpd_pkg::ERROR_W-1:0]        m_heading_error,
    output logic signed [hpd_pkg::DRIVE_W-1:0]        m_drive,
    output logic [hpd_pkg::WIDTH_W-1:0]               m_left_width,
    output logic [hpd_pkg::WIDTH_W-1:0]               m_right_width,
    // register writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [hpd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [hpd_pkg::CFG_DAT_W-1:0]        cfg_data
);
    import hpd_pkg::*;

    // configuration registers
    logic [11:0] target_reg;
    logic [7:0]  kp_reg;
    logic [6:0]  kd_reg;
    logic [15:0] neutral_reg;
    logic [15:0] pw_min_reg;
    logic [15:0] pw_max_reg;

    // stage valids and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    // stage 1: captured input
    logic [11:0] heading1_reg;
    logic [6:0]  range1_reg;
    logic        adjust1_reg;
    logic [6:0]  range_sat;

    // stage 2: wrapped error and error change
    logic signed [11:0] last_error_reg;
    logic signed [11:0] err2_reg;
    logic signed [12:0] diff2_reg;
    logic [11:0]        range30;
    logic signed [13:0] desired_raw;
    logic signed [13:0] desired_wrap;
    logic signed [13:0] desired;
    logic signed [13:0] err_raw;
    logic signed [13:0] err_wrap;
    logic signed [11:0] err_next;
    logic signed [12:0] diff_next;

    // stage 3: proportional magnitude and derivative product
    logic signed [11:0] err3_reg;
    logic [18:0]        pmag3_reg;
    logic               pneg3_reg;
    logic signed [19:0] pd3_reg;
    logic signed [11:0] err_neg;
    logic [10:0]        err_mag;
    logic [18:0]        pmag_next;
    logic signed [19:0] pd_next;

    // stage 4: proportional term divided by ten
    logic signed [11:0] err4_reg;
    logic [15:0]        q4_reg;
    logic               pneg4_reg;
    logic signed [19:0] pd4_reg;
    logic [38:0]        q_full;

    // stage 5: drive clamp and pulse widths
    logic signed [11:0] err5_reg;
    logic signed [10:0] drive5_reg;
    logic [15:0]        left5_reg;
    logic [15:0]        right5_reg;
    logic signed [16:0] pterm;
    logic signed [20:0] drive_sum;
    logic signed [10:0] drive_next;
    logic signed [17:0] left_raw;
    logic signed [17:0] right_raw;

    // raise to min first, then lower to max (max wins)
    function automatic logic [15:0] clamp_width(
        input logic signed [17:0] v,
        input logic [15:0]        lo,
        input logic [15:0]        hi
    );
        logic signed [17:0] r;
        r = v;
        if (r < $signed({2'b00, lo})) r = $signed({2'b00, lo});
        if (r > $signed({2'b00, hi})) r = $signed({2'b00, hi});
        return r[15:0];
    endfunction

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= 12'd0;
            kp_reg      <= 8'd10;
            kd_reg      <= 7'd0;
            neutral_reg <= 16'd2765;
            pw_min_reg  <= 16'd2028;
            pw_max_reg  <= 16'd3502;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TARGET_HEADING: target_reg  <= cfg_data[11:0];
                CFG_KP_TENTHS:      kp_reg      <= cfg_data[7:0];
                CFG_KD_GAIN:        kd_reg      <= cfg_data[6:0];
                CFG_PW_NEUTRAL:     neutral_reg <= cfg_data;
                CFG_PW_MIN:         pw_min_reg  <= cfg_data;
                CFG_PW_MAX:         pw_max_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its item moves on
    assign en5     = !v5_reg || m_ready;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
            last_error_reg <= '0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en2 && v1_reg) last_error_reg <= err_next;
        end
    end

    // range saturation at the input
    assign range_sat = (s_range_cm > RANGE_W'(RANGE_SAT)) ? 7'(RANGE_SAT) : s_range_cm[6:0];

    always_ff @(posedge aclk) begin
        if (en1) begin
            heading1_reg <= s_heading_now;
            range1_reg   <= range_sat;
            adjust1_reg  <= s_adjust_enable;
        end
    end

    // desired heading and wrapped error
    always_comb begin
        range30     = ({5'd0, range1_reg} << 5) - ({5'd0, range1_reg} << 1);
        desired_raw = $signed({2'b00, target_reg}) + $signed({2'b00, range30})
                      - 14'(HALF_TURN);
        if (desired_raw < 14'sd0) begin
            desired_wrap = desired_raw + 14'(FULL_TURN);
        end else if (desired_raw >= 14'(FULL_TURN)) begin
            desired_wrap = desired_raw - 14'(FULL_TURN);
        end else begin
            desired_wrap = desired_raw;
        end
        desired = adjust1_reg ? desired_wrap : $signed({2'b00, target_reg});
        err_raw = desired - $signed({2'b00, heading1_reg});
        if (err_raw < -14'(HALF_TURN)) begin
            err_wrap = err_raw + 14'(FULL_TURN);
        end else if (err_raw > 14'(HALF_TURN)) begin
            err_wrap = err_raw - 14'(FULL_TURN);
        end else begin
            err_wrap = err_raw;
        end
        err_next  = err_wrap[11:0];
        diff_next = {err_next[11], err_next} - {last_error_reg[11], last_error_reg};
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            err2_reg  <= err_next;
            diff2_reg <= diff_next;
        end
    end

    // gain products
    always_comb begin
        err_neg   = -err2_reg;
        err_mag   = err2_reg[11] ? err_neg[10:0] : err2_reg[10:0];
        pmag_next = {11'd0, kp_reg} * {8'd0, err_mag};
        pd_next   = 20'($signed({1'b0, kd_reg})) * 20'(diff2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            err3_reg  <= err2_reg;
            pmag3_reg <= pmag_next;
            pneg3_reg <= err2_reg[11];
            pd3_reg   <= pd_next;
        end
    end

    // magnitude divided by ten, truncation toward zero via the sign split
    assign q_full = {20'd0, pmag3_reg} * 39'(DIV10_MUL);

    always_ff @(posedge aclk) begin
        if (en4) begin
            err4_reg  <= err3_reg;
            q4_reg    <= q_full[DIV10_SHIFT +: 16];
            pneg4_reg <= pneg3_reg;
            pd4_reg   <= pd3_reg;
        end
    end

    // drive sum, clamp and differential widths
    always_comb begin
        pterm     = pneg4_reg ? -$signed({1'b0, q4_reg}) : $signed({1'b0, q4_reg});
        drive_sum = 21'(pterm) + 21'(pd4_reg);
        if (drive_sum > 21'(DRIVE_LIMIT)) begin
            drive_next = 11'(DRIVE_LIMIT);
        end else if (drive_sum < -21'(DRIVE_LIMIT)) begin
            drive_next = -11'(DRIVE_LIMIT);
        end else begin
            drive_next = drive_sum[10:0];
        end
        left_raw  = $signed({2'b00, neutral_reg}) + 18'(drive_next);
        right_raw = $signed({2'b00, neutral_reg}) - 18'(drive_next);
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            err5_reg   <= err4_reg;
            drive5_reg <= drive_next;
            left5_reg  <= clamp_width(left_raw, pw_min_reg, pw_max_reg);
            right5_reg <= clamp_width(right_raw, pw_min_reg, pw_max_reg);
        end
    end

    // result item
    assign m_valid         = v5_reg;
    assign m_heading_error = err5_reg;
    assign m_drive         = drive5_reg;
    assign m_left_width    = left5_reg;
    assign m_right_width   = right5_reg;

endmodule

`default_nettype wire

FILE: rtl/hpd_checker.sv
// port-level checks for the heading pd differential thrust block, with bind
`default_nettype none

module hpd_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_ready,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic signed [hpd_pkg::ERROR_W-1:0]   m_heading_error,
    input wire logic signed [hpd_pkg::DRIVE_W-1:0]   m_drive
);
    import hpd_pkg::*;

    // a waiting result item stays until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped before it was taken");

    // an empty output means the pipeline can take an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while no result is waiting");

    // wrapped error stays within a half turn
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_heading_error >= -12'(HALF_TURN)) &&
                    (m_heading_error <= 12'(HALF_TURN)))
        else $error("heading error outside a half turn");

    // drive is clamped
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive >= -11'(DRIVE_LIMIT)) && (m_drive <= 11'(DRIVE_LIMIT)))
        else $error("drive outside its limit");

endmodule

bind heading_pd_differential_thrust hpd_checker u_hpd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_heading_error (m_heading_error),
    .m_drive         (m_drive)
);

`default_nettype wire
